// File: sv/pnt_pkg.sv
// palette night tint: shared types, blend operands and soft-light table builder
// no dependencies; used by the channel lane, the top level and the testbench

package pnt_pkg;

    // blend operands, low 8 bits used
    localparam int unsigned RED_GREEN_BLEND = 8;
    localparam int unsigned BLUE_BLEND      = 128;

    // configuration register indexes
    localparam logic [1:0] REG_NIGHT_LEVEL      = 2'd0;
    localparam logic [1:0] REG_NIGHT_VALID      = 2'd1;
    localparam logic [1:0] REG_LIGHTNING_ACTIVE = 2'd2;

    localparam logic [8:0]  LEVEL_FULL = 9'd256;

    typedef logic [255:0][7:0] blend_tab_t;

    // per-stage load enables shared by the lanes
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } pnt_stage_en_t;

    function automatic longint unsigned isqrt64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bit_v;
        v   = v_in;
        res = 0;
        for (int i = 31; i >= 0; i--)
        begin
            bit_v = longint'(1) << (2 * i);
            if (v >= res + bit_v)
            begin
                v   = v - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    // exact soft-light blend of every channel value against operand b
    function automatic blend_tab_t make_blend_tab(input int unsigned b_in);
        blend_tab_t      tab;
        longint unsigned a;
        longint unsigned b;
        longint unsigned num;
        longint unsigned c;
        longint unsigned k;
        longint unsigned p;
        longint unsigned r;
        b = longint'(b_in & 32'hFF);
        for (int i = 0; i < 256; i++)
        begin
            a = longint'(i);
            if (2 * b < 255)
            begin
                num = 2 * a * b * 255 + a * a * (255 - 2 * b);
                r   = num / 65025;
            end
            else
            begin
                c = 2 * b - 255;
                k = isqrt64(c * c * 255 * a);
                p = 2 * a * (255 - b);
                r = (p + k) / 255;
            end
            if (r > 255)
            begin
                r = 255;
            end
            tab[i] = r[7:0];
        end
        return tab;
    endfunction

endpackage

// File: sv/pnt_if.sv
// palette night tint: handshake channels for entries, results and configuration
// depends on nothing; widths follow the field definitions of the block

interface pnt_entry_if;
    logic       valid;
    logic       ready;
    logic [7:0] entry_index;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    logic       last_entry;

    modport source (output valid, entry_index, blue_in, green_in, red_in, last_entry,
                    input ready);
    modport sink   (input valid, entry_index, blue_in, green_in, red_in, last_entry,
                    output ready);
endinterface

interface pnt_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] entry_index_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_out;

    modport source (output valid, entry_index_out, red_out, green_out, blue_out, last_out,
                    input ready);
    modport sink   (input valid, entry_index_out, red_out, green_out, blue_out, last_out,
                    output ready);
endinterface

interface pnt_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/pnt_lane.sv
// palette night tint: three-stage datapath for one colour channel
// depends on pnt_pkg for the stage enable struct and the table type

module pnt_lane (
    input  logic                   clk,
    input  pnt_pkg::pnt_stage_en_t en,
    input  pnt_pkg::blend_tab_t    tab,
    input  logic [8:0]             level,
    input  logic [7:0]             chan,
    output logic [7:0]             chan_out
);

    logic [7:0]  a1_reg;
    logic [7:0]  s1_reg;
    logic [7:0]  a2_reg;
    logic        neg2_reg;
    logic [15:0] prod2_reg;
    logic [7:0]  out3_reg;

    logic [7:0]  mag;
    logic        neg;
    logic [16:0] prod;
    logic [7:0]  step;
    logic [7:0]  out3_next;

    // distance to the blend, taken as magnitude so the shift truncates toward zero
    always_comb
    begin
        neg  = (s1_reg < a1_reg);
        mag  = neg ? (a1_reg - s1_reg) : (s1_reg - a1_reg);
        prod = {9'd0, mag} * {8'd0, level};
    end

    // result stays between a and s, no wrap
    always_comb
    begin
        step      = prod2_reg[15:8];
        out3_next = neg2_reg ? (a2_reg - step) : (a2_reg + step);
    end

    always_ff @(posedge clk)
    begin
        if (en.ld1)
        begin
            a1_reg <= chan;
            s1_reg <= tab[chan];
        end
        if (en.ld2)
        begin
            a2_reg    <= a1_reg;
            neg2_reg  <= neg;
            prod2_reg <= prod[15:0];
        end
        if (en.ld3)
        begin
            out3_reg <= out3_next;
        end
    end

    assign chan_out = out3_reg;

endmodule

// File: sv/palette_night_tint_core.sv
// Palette night tint, top level: config registers, pipeline control and three lanes.
// Depends on pnt_pkg, the channels in pnt_if and the per-channel datapath pnt_lane.
//
// Each palette entry goes through three register stages: soft-light table lookup,
// one 8x9 multiply of the distance to the blend by the night level, then the add
// or subtract that lands in the output register. One entry is taken every cycle
// while the result side does not stall the pipeline, so throughput is one entry
// per clock when nothing stalls. Stalls on the result side back up stage by stage;
// a bubble in any stage still lets the input side keep moving. Tinting applies
// only while night_valid is set and lightning_active is clear; a night level above
// 256 acts as a full blend. Configuration writes are always accepted and must be
// made while no entry is in flight.

module palette_night_tint_core (
    input  logic        clk,
    input  logic        rst_n,
    pnt_cfg_if.sink     cfg,
    pnt_entry_if.sink   entry,
    pnt_result_if.source result
);

    localparam pnt_pkg::blend_tab_t RG_TAB =
        pnt_pkg::make_blend_tab(pnt_pkg::RED_GREEN_BLEND);
    localparam pnt_pkg::blend_tab_t BL_TAB =
        pnt_pkg::make_blend_tab(pnt_pkg::BLUE_BLEND);

    logic [8:0] night_level_reg;
    logic       night_valid_reg;
    logic       lightning_active_reg;

    logic       v1_reg, v2_reg, v3_reg;
    logic       v1_next, v2_next, v3_next;
    logic [7:0] idx1_reg, idx2_reg, idx3_reg;
    logic       last1_reg, last2_reg, last3_reg;

    logic [8:0]             level;
    pnt_pkg::pnt_stage_en_t en;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            night_level_reg      <= '0;
            night_valid_reg      <= 1'b0;
            lightning_active_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                pnt_pkg::REG_NIGHT_LEVEL:      night_level_reg      <= cfg.data;
                pnt_pkg::REG_NIGHT_VALID:      night_valid_reg      <= cfg.data[0];
                pnt_pkg::REG_LIGHTNING_ACTIVE: lightning_active_reg <= cfg.data[0];
                default:                       ;
            endcase
        end
    end

    // effective factor: zero when tinting is off, saturated to full
    always_comb
    begin
        if (!night_valid_reg || lightning_active_reg)
            level = '0;
        else if (night_level_reg > pnt_pkg::LEVEL_FULL)
            level = pnt_pkg::LEVEL_FULL;
        else
            level = night_level_reg;
    end

    // a stage loads when it is empty or the next one takes its item
    always_comb
    begin
        en.ld3  = !v3_reg || result.ready;
        en.ld2  = !v2_reg || en.ld3;
        en.ld1  = !v1_reg || en.ld2;
        v1_next = en.ld1 ? entry.valid : v1_reg;
        v2_next = en.ld2 ? v1_reg : v2_reg;
        v3_next = en.ld3 ? v2_reg : v3_reg;
    end

    assign entry.ready = en.ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.ld1)
        begin
            idx1_reg  <= entry.entry_index;
            last1_reg <= entry.last_entry;
        end
        if (en.ld2)
        begin
            idx2_reg  <= idx1_reg;
            last2_reg <= last1_reg;
        end
        if (en.ld3)
        begin
            idx3_reg  <= idx2_reg;
            last3_reg <= last2_reg;
        end
    end

    pnt_lane u_red (
        .clk      (clk),
        .en       (en),
        .tab      (RG_TAB),
        .level    (level),
        .chan     (entry.red_in),
        .chan_out (result.red_out)
    );

    pnt_lane u_green (
        .clk      (clk),
        .en       (en),
        .tab      (RG_TAB),
        .level    (level),
        .chan     (entry.green_in),
        .chan_out (result.green_out)
    );

    pnt_lane u_blue (
        .clk      (clk),
        .en       (en),
        .tab      (BL_TAB),
        .level    (level),
        .chan     (entry.blue_in),
        .chan_out (result.blue_out)
    );

    assign result.valid           = v3_reg;
    assign result.entry_index_out = idx3_reg;
    assign result.last_out        = last3_reg;

endmodule

// File: tb/pnt_tint_check.sv
// palette night tint testbench: watches the config, entry and result channels,
// predicts each tinted entry and compares it with what the core returns
// depends on pnt_pkg and the channel interfaces in pnt_if
`timescale 1ns / 100ps

module pnt_tint_check (
    input  logic  clk,
    input  logic  rst_n,
    pnt_cfg_if    cfg,
    pnt_entry_if  entry,
    pnt_result_if result,
    output int    mismatches,
    output int    pending
);

    localparam logic [7:0] RG_OPERAND   = 8'(pnt_pkg::RED_GREEN_BLEND & 255);
    localparam logic [7:0] BLUE_OPERAND = 8'(pnt_pkg::BLUE_BLEND & 255);

    typedef struct packed {
        logic [7:0] slot;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } tinted_t;

    logic [8:0] night_level;
    logic       night_on;
    logic       flash_on;
    tinted_t    tint_q[$];
    int         fault_count;

    function automatic logic [31:0] root_floor(input longint unsigned v);
        longint unsigned acc;
        longint unsigned trial;
        acc = 0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = acc | (longint'(1) << i);
            if (trial * trial <= v)
                acc = trial;
        end
        return acc[31:0];
    endfunction

    // exact soft light of channel against operand, scaled to 0..255
    function automatic logic [7:0] blend_value(input logic [7:0] chan,
                                               input logic [7:0] operand);
        longint unsigned a;
        longint unsigned b;
        longint unsigned q;
        a = chan;
        b = operand;
        if (2 * b < 255)
            q = (2 * a * b * 255 + a * a * (255 - 2 * b)) / 65025;
        else
            q = (2 * a * (255 - b)
                 + root_floor((2 * b - 255) * (2 * b - 255) * 255 * a)) / 255;
        if (q > 255)
            q = 255;
        return q[7:0];
    endfunction

    // move chan toward blend by level/256, truncating toward the source value
    function automatic logic [7:0] toward_blend(input logic [7:0] chan, input logic [7:0] blend,
                                                input logic [8:0] level);
        logic [16:0] step;
        if (level == 9'd0)
            return chan;
        if (level >= pnt_pkg::LEVEL_FULL)
            return blend;
        if (blend >= chan)
        begin
            step = 17'(blend - chan) * 17'(level);
            return chan + step[15:8];
        end
        step = 17'(chan - blend) * 17'(level);
        return chan - step[15:8];
    endfunction

    function automatic tinted_t tint_entry(input logic [7:0] slot, input logic [7:0] blue,
                                           input logic [7:0] green, input logic [7:0] red,
                                           input logic last);
        tinted_t t;
        t.slot  = slot;
        t.red   = red;
        t.green = green;
        t.blue  = blue;
        t.last  = last;
        if (night_on && !flash_on)
        begin
            t.red   = toward_blend(red,   blend_value(red,   RG_OPERAND),   night_level);
            t.green = toward_blend(green, blend_value(green, RG_OPERAND),   night_level);
            t.blue  = toward_blend(blue,  blend_value(blue,  BLUE_OPERAND), night_level);
        end
        return t;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            night_level <= 9'd0;
            night_on    <= 1'b0;
            flash_on    <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                pnt_pkg::REG_NIGHT_LEVEL:      night_level <= cfg.data;
                pnt_pkg::REG_NIGHT_VALID:      night_on    <= cfg.data[0];
                pnt_pkg::REG_LIGHTNING_ACTIVE: flash_on    <= cfg.data[0];
                default: ;
            endcase
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        tinted_t want;
        tinted_t seen;
        if (!rst_n)
        begin
            tint_q.delete();
            fault_count = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (entry.valid && entry.ready)
                tint_q.push_back(tint_entry(entry.entry_index, entry.blue_in, entry.green_in,
                                            entry.red_in, entry.last_entry));
            if (result.valid && result.ready)
            begin
                seen.slot  = result.entry_index_out;
                seen.red   = result.red_out;
                seen.green = result.green_out;
                seen.blue  = result.blue_out;
                seen.last  = result.last_out;
                if (tint_q.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("%0t: result transfer with nothing outstanding: slot %h", $realtime,
                                 seen.slot);
                    fault_count++;
                end
                else
                begin
                    want = tint_q.pop_front();
                    if (want !== seen)
                    begin
                        if (fault_count < 10)
                            $display({"%0t: slot %h/%h red %h/%h green %h/%h blue %h/%h ",
                                      "last %b/%b (expected/actual)"}, $realtime,
                                     want.slot, seen.slot, want.red, seen.red,
                                     want.green, seen.green, want.blue, seen.blue,
                                     want.last, seen.last);
                        fault_count++;
                    end
                end
            end
            mismatches <= fault_count;
            pending    <= tint_q.size();
        end
    end

endmodule

// File: tb/testbench.sv
// palette night tint testbench top: clock, reset, entry and config stimulus,
// result-side back-pressure and the verdict
// depends on pnt_pkg, pnt_if, palette_night_tint_core and pnt_tint_check
`timescale 1ns / 100ps

module testbench;

    localparam int RUN_LIMIT      = 400000;
    localparam int RANDOM_ENTRIES = 2000;
    localparam int PHASE_ENTRIES  = 120;
    localparam int HOLD_CYCLES    = 150;

    logic clk;
    logic rst_n;
    int   pending;
    int   mismatches;
    int   cycle_count = 0;
    int   entries_sent = 0;
    bit   sender_burst = 1'b0;

    pnt_cfg_if    cfg_ch();
    pnt_entry_if  entry_ch();
    pnt_result_if result_ch();

    palette_night_tint_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .entry  (entry_ch),
        .result (result_ch)
    );

    pnt_tint_check u_tint_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .entry      (entry_ch),
        .result     (result_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [8:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 9'd0;
            1:       return pnt_pkg::LEVEL_FULL;
            2:       return 9'd511;
            3:       return 9'd1;
            4:       return 9'd255;
            5:       return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(0, 511));
        endcase
    endfunction

    // called at a clock edge; returns at the edge of the transfer with valid still high
    task automatic push_entry(input logic [7:0] slot, input logic [7:0] blue,
                              input logic [7:0] green, input logic [7:0] red, input logic last);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            entry_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        entry_ch.valid       <= 1'b1;
        entry_ch.entry_index <= slot;
        entry_ch.blue_in     <= blue;
        entry_ch.green_in    <= green;
        entry_ch.red_in      <= red;
        entry_ch.last_entry  <= last;
        do @(posedge clk); while (!entry_ch.ready);
        entries_sent++;
    endtask

    task automatic drain_results();
        entry_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // registers only change with the pipeline empty
    task automatic retune(input logic [8:0] level, input logic night, input logic flash);
        logic [1:0] regs [3];
        logic [8:0] vals [3];
        logic [7:0] junk;
        junk    = 8'($urandom);
        regs[0] = pnt_pkg::REG_NIGHT_LEVEL;
        regs[1] = pnt_pkg::REG_NIGHT_VALID;
        regs[2] = pnt_pkg::REG_LIGHTNING_ACTIVE;
        vals[0] = level;
        vals[1] = {junk, night};
        vals[2] = {~junk, flash};
        drain_results();
        cfg_ch.valid <= 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cfg_ch.index <= regs[i];
            cfg_ch.data  <= vals[i];
            do @(posedge clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // mostly update ranges of consecutive slots closed by a last mark, some stray entries
    task automatic send_ranges(input int count);
        int first;
        int base;
        int span;
        first = entries_sent;
        while (entries_sent - first < count)
        begin
            if ($urandom_range(0, 7) == 0)
                push_entry(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                           1'($urandom_range(0, 1)));
            else
            begin
                base = $urandom_range(0, 255);
                span = $urandom_range(1, 24);
                for (int k = 0; k < span; k++)
                    push_entry(8'(base + k), pick_byte(), pick_byte(), pick_byte(),
                               k == span - 1);
            end
        end
    endtask

    // result side: random stalls, calm stretches and two long hold-offs
    initial
    begin
        int stall;
        int taken;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        result_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (taken == 400 || taken == 1300)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm)
            begin
                stall = $urandom_range(0, 6);
                if (stall != 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            taken++;
            if (taken % 64 == 0)
                calm = ($urandom_range(0, 2) == 0);
        end
    end

    initial
    begin
        int first;
        rst_n                = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = pnt_pkg::REG_NIGHT_LEVEL;
        cfg_ch.data          = 9'd0;
        entry_ch.valid       = 1'b0;
        entry_ch.entry_index = 8'd0;
        entry_ch.blue_in     = 8'd0;
        entry_ch.green_in    = 8'd0;
        entry_ch.red_in      = 8'd0;
        entry_ch.last_entry  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings leave colours untouched
        push_entry(8'd7, 8'd200, 8'd100, 8'd50, 1'b0);
        push_entry(8'd8, 8'd1, 8'd254, 8'd128, 1'b1);

        // full blend, channel extremes and alternating bits
        retune(pnt_pkg::LEVEL_FULL, 1'b1, 1'b0);
        push_entry(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        push_entry(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        push_entry(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0);
        push_entry(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1);
        push_entry(8'h01, 8'd128, 8'd8, 8'd200, 1'b0);

        // level above full saturates to the full blend
        retune(9'd511, 1'b1, 1'b0);
        push_entry(8'd10, 8'd30, 8'd160, 8'd250, 1'b0);
        push_entry(8'd11, 8'd127, 8'd129, 8'd3, 1'b1);

        // partial blend in both directions
        retune(9'd128, 1'b1, 1'b0);
        push_entry(8'd20, 8'd0, 8'd255, 8'd100, 1'b0);
        push_entry(8'd21, 8'd255, 8'd2, 8'd9, 1'b0);
        push_entry(8'd22, 8'd64, 8'd40, 8'd180, 1'b1);

        // zero level passes through
        retune(9'd0, 1'b1, 1'b0);
        push_entry(8'd30, 8'd90, 8'd45, 8'd230, 1'b0);
        push_entry(8'd31, 8'd255, 8'd0, 8'd17, 1'b1);

        // lightning flash suppresses the tint
        retune(9'd300, 1'b1, 1'b1);
        push_entry(8'd40, 8'd200, 8'd100, 8'd50, 1'b0);
        push_entry(8'd41, 8'd5, 8'd250, 8'd128, 1'b1);

        // tint disabled
        retune(pnt_pkg::LEVEL_FULL, 1'b0, 1'b0);
        push_entry(8'd50, 8'd200, 8'd100, 8'd50, 1'b0);
        push_entry(8'd51, 8'd5, 8'd250, 8'd128, 1'b1);

        first = entries_sent;
        while (entries_sent - first < RANDOM_ENTRIES)
        begin
            retune(pick_level(), $urandom_range(0, 4) != 0, $urandom_range(0, 4) == 0);
            sender_burst = ($urandom_range(0, 3) == 0);
            send_ranges(PHASE_ENTRIES);
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
